// ----- rtl/core/cmsr_pkg.sv -----
`default_nettype none
package cmsr_pkg;
    localparam int MaxNodesDef  = 64;
    localparam int NumLabelsDef = 4;
    localparam int ValW         = 32;
    localparam int LenW         = 7;
    localparam int TolW         = 31;

    localparam logic [2:0] OP_LOAD_U = 3'd0;
    localparam logic [2:0] OP_LOAD_E = 3'd1;
    localparam logic [2:0] OP_RUN    = 3'd2;
    localparam logic [2:0] OP_READ_U = 3'd3;
    localparam logic [2:0] OP_READ_E = 3'd4;

    localparam logic [1:0] KIND_RUN = 2'd0;
    localparam logic [1:0] KIND_U   = 2'd1;
    localparam logic [1:0] KIND_E   = 2'd2;

    localparam logic CFG_LEN = 1'b0;
    localparam logic CFG_TOL = 1'b1;

    typedef struct packed {
        logic [2:0]        op;
        logic [5:0]        node_index;
        logic [1:0]        label_a;
        logic [1:0]        label_b;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               consistent;
        logic [1:0]         result_kind;
    } t_out;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic sub);
        logic signed [32:0] s;
        begin
            s = sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
            if (s[32] != s[31]) sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            else sat_add = s[31:0];
        end
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/chain_min_sum_reparametrization_unit.sv -----
// Min-sum reparametrization on a chain. A load is written at its transfer and the input is
// ready again on the next cycle; a read goes through S_RD and then S_RDW, which registers it.
// A run walks every edge forward then backward. For each edge and target label it scans
// NUM_LABELS unary/weight pairs (S_MRD, S_MWT, S_MACC each), updates the neighbor unary
// (S_NRD, S_NWT, S_NWR) and then the NUM_LABELS weights (S_ERD, S_EWT, S_EWR each), all
// through one saturating adder. A minimum scan over every node (S_CRD and S_CACC per label,
// then S_DONE) follows, after which the result is registered.
// The input stays blocked until the result is taken. Stores hold no reset value; read only
// what was written.
`default_nettype none
module chain_min_sum_reparametrization_unit
    import cmsr_pkg::*;
#(
    parameter int MAX_NODES  = MaxNodesDef,
    parameter int NUM_LABELS = NumLabelsDef
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire t_in    i_data,
    output logic        o_valid,
    input  wire         i_ready,
    output t_out        o_data,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire [31:0]  i_cfg_data
);
    localparam int NW = $clog2(MAX_NODES);
    localparam int LW = $clog2(NUM_LABELS);
    localparam int UAW = NW + LW;
    localparam int EAW = NW + 2*LW;
    localparam int CW = NW + 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_RDO = 4'd3,
        S_MRD = 4'd4, S_MACC = 4'd5, S_NRD = 4'd6, S_NWR = 4'd7, S_ERD = 4'd8,
        S_EWR = 4'd9, S_CRD = 4'd10, S_CACC = 4'd11, S_DONE = 4'd12, S_MWT = 4'd13,
        S_NWT = 4'd14, S_EWT = 4'd15;

    logic [3:0] r_st;
    logic [LenW-1:0] r_len;
    logic [TolW-1:0] r_tol;
    logic r_cons;
    t_in r_in;
    logic r_bwd;
    logic [CW-1:0] r_i;
    logic [LW:0] r_t, r_s;
    logic signed [31:0] r_min, r_u, r_base;
    logic r_ok;

    logic u_we, e_we;
    logic [UAW-1:0] u_wa, u_ra;
    logic [EAW-1:0] e_wa, e_ra;
    logic [31:0] u_wd, e_wd, u_rd, e_rd;

    cmsr_ram #(.WIDTH(32), .DEPTH(MAX_NODES*NUM_LABELS)) u_ustore (
        .i_clk, .i_we(u_we), .i_waddr(u_wa), .i_wdata(u_wd), .i_raddr(u_ra), .o_rdata(u_rd));
    cmsr_ram #(.WIDTH(32), .DEPTH(MAX_NODES*NUM_LABELS*NUM_LABELS)) u_estore (
        .i_clk, .i_we(e_we), .i_waddr(e_wa), .i_wdata(e_wd), .i_raddr(e_ra), .o_rdata(e_rd));

    // used chain length
    logic [CW-1:0] len_u;
    always_comb begin
        if (r_len < 7'd2) len_u = CW'(2);
        else if ({25'd0, r_len} > MAX_NODES) len_u = CW'(MAX_NODES);
        else len_u = CW'(r_len);
    end

    // edge index and node sides for current step
    logic [NW-1:0] edge_i, src_n, dst_n;
    always_comb begin
        edge_i = r_bwd ? NW'(r_i - CW'(1)) : NW'(r_i);
        src_n  = NW'(r_i);
        dst_n  = r_bwd ? NW'(r_i - CW'(1)) : NW'(r_i + CW'(1));
    end
    logic [LW-1:0] t_l, s_l;
    assign t_l = r_t[LW-1:0];
    assign s_l = r_s[LW-1:0];
    logic [EAW-1:0] e_cur;
    assign e_cur = r_bwd ? {edge_i, t_l, s_l} : {edge_i, s_l, t_l};

    logic in_ok;
    assign in_ok = ({26'd0, i_data.node_index} < MAX_NODES)
        && ({30'd0, i_data.label_a} < NUM_LABELS) && ({30'd0, i_data.label_b} < NUM_LABELS);
    logic u_ok_in;
    assign u_ok_in = ({26'd0, i_data.node_index} < MAX_NODES)
        && ({30'd0, i_data.label_a} < NUM_LABELS);

    // shared saturating adder
    logic signed [31:0] add_a, add_b, add_y;
    logic add_sub;
    always_comb begin
        add_a = r_u; add_b = e_rd; add_sub = 1'b0;
        case (r_st)
            S_NWR: begin
                add_a = u_rd; add_b = r_min;
            end
            S_EWR: begin
                add_a = e_rd; add_b = r_min; add_sub = 1'b1;
            end
            default: ;
        endcase
    end
    assign add_y = sat_add(add_a, add_b, add_sub);

    logic signed [32:0] d33;
    assign d33 = {r_u[31], r_u} - {r_base[31], r_base};

    assign o_ready = (r_st == S_IDLE) && !o_valid;
    assign o_cfg_ready = (r_st == S_IDLE);

    always_comb begin
        u_we = 1'b0; e_we = 1'b0;
        u_wa = {NW'(i_data.node_index), LW'(i_data.label_a)};
        u_wd = i_data.value;
        e_wa = {NW'(i_data.node_index), LW'(i_data.label_a), LW'(i_data.label_b)};
        e_wd = i_data.value;
        u_ra = {src_n, s_l};
        e_ra = e_cur;
        if (r_st == S_IDLE && i_valid && o_ready) begin
            if (i_data.op == OP_LOAD_U && u_ok_in) u_we = 1'b1;
            if (i_data.op == OP_LOAD_E && in_ok) e_we = 1'b1;
        end
        case (r_st)
            S_RD: begin
                u_ra = {NW'(r_in.node_index), LW'(r_in.label_a)};
                e_ra = {NW'(r_in.node_index), LW'(r_in.label_a), LW'(r_in.label_b)};
            end
            S_NRD, S_NWT: u_ra = {dst_n, t_l};
            S_NWR: begin
                u_we = 1'b1; u_wa = {dst_n, t_l}; u_wd = add_y;
            end
            S_EWR: begin
                e_we = 1'b1; e_wa = e_cur; e_wd = add_y;
            end
            S_CRD: u_ra = {NW'(r_i), s_l};
            default: ;
        endcase
    end

    logic last_s;
    assign last_s = (r_s == (LW+1)'(NUM_LABELS-1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_len <= LenW'(2); r_tol <= TolW'(66); r_cons <= 1'b1;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_LEN) r_len <= i_cfg_data[LenW-1:0];
                else r_tol <= i_cfg_data[TolW-1:0];
            end
            case (r_st)
                S_IDLE: if (i_valid && o_ready) begin
                    r_in <= i_data;
                    if (i_data.op == OP_READ_U || i_data.op == OP_READ_E) r_st <= S_RD;
                    else if (i_data.op == OP_RUN) begin
                        r_st <= S_MRD; r_bwd <= 1'b0; r_i <= '0; r_t <= '0; r_s <= '0;
                    end
                end
                S_RD: r_st <= S_RDW;
                S_RDW: begin
                    o_data.consistent <= r_cons;
                    if (r_in.op == OP_READ_U) begin
                        o_data.result_kind <= KIND_U;
                        o_data.result_value <= ({26'd0, r_in.node_index} < MAX_NODES &&
                            {30'd0, r_in.label_a} < NUM_LABELS) ? u_rd : 32'sd0;
                    end else begin
                        o_data.result_kind <= KIND_E;
                        o_data.result_value <= ({26'd0, r_in.node_index} < MAX_NODES &&
                            {30'd0, r_in.label_a} < NUM_LABELS &&
                            {30'd0, r_in.label_b} < NUM_LABELS) ? e_rd : 32'sd0;
                    end
                    o_valid <= 1'b1; r_st <= S_IDLE;
                end
                S_MRD: r_st <= S_MWT;
                S_MWT: begin r_u <= u_rd; r_st <= S_MACC; end
                S_MACC: begin
                    if (r_s == '0 || add_y < r_min) r_min <= add_y;
                    if (last_s) begin r_s <= '0; r_st <= S_NRD; end
                    else begin r_s <= r_s + 1'b1; r_st <= S_MRD; end
                end
                S_NRD: r_st <= S_NWT;
                S_NWT: r_st <= S_NWR;
                S_NWR: r_st <= S_ERD;
                S_ERD: r_st <= S_EWT;
                S_EWT: r_st <= S_EWR;
                S_EWR: begin
                    if (!last_s) begin r_s <= r_s + 1'b1; r_st <= S_ERD; end
                    else begin
                        r_s <= '0;
                        r_st <= S_MRD;
                        if (r_t != (LW+1)'(NUM_LABELS-1)) r_t <= r_t + 1'b1;
                        else begin
                            r_t <= '0;
                            if (!r_bwd) begin
                                if (r_i + CW'(2) >= len_u) begin
                                    r_bwd <= 1'b1; r_i <= len_u - CW'(1);
                                end else r_i <= r_i + CW'(1);
                            end else if (r_i == CW'(1)) begin
                                r_i <= '0; r_ok <= 1'b1; r_st <= S_CRD;
                            end else r_i <= r_i - CW'(1);
                        end
                    end
                end
                S_CRD: r_st <= S_CACC;
                S_CACC: begin
                    if (r_s == '0 || $signed(u_rd) < r_u) r_u <= u_rd;
                    if (last_s) begin
                        r_s <= '0; r_st <= S_DONE;
                    end else begin
                        r_s <= r_s + 1'b1; r_st <= S_CRD;
                    end
                end
                S_DONE: begin
                    if (r_i == '0) r_base <= r_u;
                    else if ((d33[32] ? -d33 : d33) > {2'b0, r_tol}) r_ok <= 1'b0;
                    if (r_i + CW'(1) >= len_u) begin
                        r_st <= S_IDLE;
                        r_cons <= ((r_i != '0) && ((d33[32] ? -d33 : d33) > {2'b0, r_tol}))
                            ? 1'b0 : r_ok;
                        o_data.result_kind <= KIND_RUN;
                        o_data.result_value <= (r_i == '0) ? r_u : r_base;
                        o_data.consistent <= ((r_i != '0) &&
                            ((d33[32] ? -d33 : d33) > {2'b0, r_tol})) ? 1'b0 : r_ok;
                        o_valid <= 1'b1;
                    end else begin
                        r_i <= r_i + CW'(1); r_st <= S_CRD;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !o_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.result_kind == KIND_RUN || o_data.result_kind == KIND_U ||
        o_data.result_kind == KIND_E)) else $error("bad kind");
endmodule
`default_nettype wire

// ----- rtl/core/cmsr_ram.sv -----
`default_nettype none
module cmsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
